### sv/dpb_pkg.sv
package dpb_pkg;

    localparam int PARAM_COUNT    = 256;
    localparam int IDX_W          = 8;
    localparam int MAX_STEP_COUNT = 256;
    localparam int STEPS_W        = 9;
    localparam int STEP_W         = 8;
    localparam int VAL_W          = 16;
    localparam int TIME_W         = 24;
    localparam int DT_W           = 20;
    localparam int DIV_NUM_W      = 25;
    localparam int DIV_DEN_W      = 9;

    localparam logic [VAL_W-1:0]   FULL_SCALE    = 16'hFFFF;
    localparam logic [VAL_W-1:0]   HALF_SCALE    = 16'h8000;
    localparam logic [VAL_W-1:0]   MORPH_LOW     = 16'd6554;
    localparam logic [VAL_W-1:0]   MORPH_HIGH    = 16'd58982;
    localparam logic [STEPS_W-1:0] DEFAULT_STEPS = 9'd10;
    localparam logic [16:0]        TWO_FULL      = 17'd131070;

    localparam logic [1:0] CMD_PROCESS = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_FORCE   = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    localparam logic [2:0] STRAT_SWITCH = 3'd0;
    localparam logic [2:0] STRAT_XFADE  = 3'd1;
    localparam logic [2:0] STRAT_STEP   = 3'd2;
    localparam logic [2:0] STRAT_HOLD   = 3'd3;
    localparam logic [2:0] STRAT_FOLLOW = 3'd4;

    localparam logic [1:0] REG_THRESH    = 2'd0;
    localparam logic [1:0] REG_HYST      = 2'd1;
    localparam logic [1:0] REG_HOLD_BLK  = 2'd2;
    localparam logic [1:0] REG_HOLD_TIME = 2'd3;

    typedef struct packed {
        logic [VAL_W-1:0]  thresh;
        logic [VAL_W-1:0]  hyst;
        logic [VAL_W-1:0]  hold_blk;
        logic [TIME_W-1:0] hold_time;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         command;
        logic [IDX_W-1:0]   param_index;
        logic [VAL_W-1:0]   sample_value;
        logic [VAL_W-1:0]   morph_amount;
        logic [DT_W-1:0]    elapsed_us;
        logic               discrete_flag;
        logic [2:0]         strategy_code;
        logic [STEPS_W-1:0] step_total;
    } t_req;

    typedef struct packed {
        logic               disc;
        logic [2:0]         strat;
        logic [STEPS_W-1:0] steps;
        logic [VAL_W-1:0]   value;
        logic [STEP_W-1:0]  step;
        logic [VAL_W-1:0]   bho;
        logic [TIME_W-1:0]  tho;
    } t_ent;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_STEP,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    function automatic t_ent ent_reset();
        t_ent e;
        e       = '0;
        e.steps = DEFAULT_STEPS;
        return e;
    endfunction

endpackage

### sv/dpb_in_if.sv
interface dpb_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [dpb_pkg::IDX_W-1:0]     param_index;
    logic [dpb_pkg::VAL_W-1:0]     sample_value;
    logic [dpb_pkg::VAL_W-1:0]     morph_amount;
    logic [dpb_pkg::DT_W-1:0]      elapsed_us;
    logic                          discrete_flag;
    logic [2:0]                    strategy_code;
    logic [dpb_pkg::STEPS_W-1:0]   step_total;

    modport source (output valid, command, param_index, sample_value, morph_amount,
                    elapsed_us, discrete_flag, strategy_code, step_total,
                    input ready);
    modport sink   (input valid, command, param_index, sample_value, morph_amount,
                    elapsed_us, discrete_flag, strategy_code, step_total,
                    output ready);
endinterface

### sv/dpb_out_if.sv
interface dpb_out_if;
    logic                      valid;
    logic                      ready;
    logic [dpb_pkg::IDX_W-1:0] out_index;
    logic [dpb_pkg::VAL_W-1:0] out_value;

    modport source (output valid, out_index, out_value, input ready);
    modport sink   (input valid, out_index, out_value, output ready);
endinterface

### sv/dpb_ram.sv
module dpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### sv/dpb_front.sv
module dpb_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dpb_in_if.sink          i_req,
    output dpb_pkg::t_req   o_q_data,
    output logic            o_q_valid,
    input  logic            i_q_pop
);
    dpb_pkg::t_req r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    dpb_pkg::t_req in_req;

    assign i_req.ready = (r_cnt != 2'd2);
    // command three carries no work and is dropped here
    assign push = i_req.valid && i_req.ready && (i_req.command != dpb_pkg::CMD_NONE);

    assign in_req.command       = i_req.command;
    assign in_req.param_index   = i_req.param_index;
    assign in_req.sample_value  = i_req.sample_value;
    assign in_req.morph_amount  = i_req.morph_amount;
    assign in_req.elapsed_us    = i_req.elapsed_us;
    assign in_req.discrete_flag = i_req.discrete_flag;
    assign in_req.strategy_code = i_req.strategy_code;
    assign in_req.step_total    = i_req.step_total;

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= in_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

### sv/dpb_div.sv
module dpb_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dpb_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [dpb_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_done,
    output logic [dpb_pkg::DIV_NUM_W-1:0]  o_quo
);
    localparam int NW = dpb_pkg::DIV_NUM_W;
    localparam int DW = dpb_pkg::DIV_DEN_W;

    logic [NW-1:0]          r_num;
    logic [DW-1:0]          r_den;
    logic [DW-1:0]          r_rem;
    logic [4:0]             r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [DW:0]            rem2;
    logic                   qbit;
    logic [DW-1:0]          n_rem;

    always_comb begin
        rem2  = {r_rem, r_num[NW-1]};
        qbit  = (rem2 >= {1'b0, r_den});
        n_rem = qbit ? DW'(rem2 - {1'b0, r_den}) : rem2[DW-1:0];
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= 5'(NW - 1);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[NW-2:0], qbit};
            r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end
endmodule

### sv/dpb_back.sv
module dpb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dpb_pkg::t_cfg   i_cfg,
    input  dpb_pkg::t_req   i_q_data,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    dpb_out_if.source       o_res
);
    localparam int EW = $bits(dpb_pkg::t_ent);

    dpb_pkg::t_state r_state, n_state;
    dpb_pkg::t_req   r_req, n_req;
    dpb_pkg::t_ent   r_ent, n_ent;
    logic [dpb_pkg::VAL_W-1:0]     r_res, n_res;
    logic [23:0]                   r_prod, n_prod;
    logic [dpb_pkg::PARAM_COUNT-1:0] r_vld;
    logic                          r_rd_vld, n_rd_vld;
    logic                          r_out_valid;
    logic [dpb_pkg::IDX_W-1:0]     r_out_idx;
    logic [dpb_pkg::VAL_W-1:0]     r_out_val;

    logic [EW-1:0]                 rdata;
    logic                          we;
    logic                          out_load;
    dpb_pkg::t_ent                 rd_ent;
    dpb_pkg::t_ent                 e;
    logic                          div_start;
    logic                          div_done;
    logic [dpb_pkg::DIV_NUM_W-1:0] div_num;
    logic [dpb_pkg::DIV_NUM_W-1:0] div_quo;
    logic [dpb_pkg::STEP_W-1:0]    m;
    logic                          high;
    logic                          want;
    logic signed [17:0]            thr;
    logic [23:0]                   xq;
    logic [16:0]                   rq;
    logic [8:0]                    q;
    logic [dpb_pkg::STEP_W-1:0]    target;
    logic [dpb_pkg::STEP_W-1:0]    step_dist;
    logic [dpb_pkg::STEPS_W-1:0]   tot;

    dpb_ram #(.WIDTH(EW), .DEPTH(dpb_pkg::PARAM_COUNT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_req.param_index),
        .i_wdata (r_ent),
        .i_raddr (i_q_data.param_index),
        .o_rdata (rdata)
    );

    dpb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   ({m, 1'b0}),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign rd_ent  = r_rd_vld ? dpb_pkg::t_ent'(rdata) : dpb_pkg::ent_reset();
    assign m       = dpb_pkg::STEP_W'(r_ent.steps - 9'd1);
    assign div_num = dpb_pkg::DIV_NUM_W'(r_ent.step)
                   * dpb_pkg::DIV_NUM_W'(dpb_pkg::TWO_FULL)
                   + dpb_pkg::DIV_NUM_W'(m);

    assign o_res.valid     = r_out_valid;
    assign o_res.out_index = r_out_idx;
    assign o_res.out_value = r_out_val;

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_ent     = r_ent;
        n_res     = r_res;
        n_prod    = r_prod;
        n_rd_vld  = r_rd_vld;
        o_q_pop   = 1'b0;
        we        = 1'b0;
        out_load  = 1'b0;
        div_start = 1'b0;
        e         = rd_ent;
        high      = 1'b0;
        want      = 1'b0;
        thr       = '0;
        xq        = '0;
        rq        = '0;
        q         = '0;
        target    = '0;
        step_dist = '0;
        tot       = '0;
        unique case (r_state)
            dpb_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_req    = i_q_data;
                    n_rd_vld = r_vld[i_q_data.param_index];
                    n_state  = dpb_pkg::S_CALC;
                end
            end
            dpb_pkg::S_CALC: begin
                n_state = dpb_pkg::S_DONE;
                n_res   = r_req.sample_value;
                case (r_req.command)
                    dpb_pkg::CMD_WRITE: begin
                        tot = r_req.step_total;
                        if (tot == 9'd0) begin
                            tot = 9'd1;
                        end else if (tot > 9'(dpb_pkg::MAX_STEP_COUNT)) begin
                            tot = 9'(dpb_pkg::MAX_STEP_COUNT);
                        end
                        e.disc  = r_req.discrete_flag;
                        e.strat = r_req.strategy_code;
                        e.steps = tot;
                    end
                    dpb_pkg::CMD_FORCE: begin
                        e.value = r_req.sample_value;
                        e.bho   = '0;
                    end
                    default: begin
                        if (e.disc) begin
                            if (e.bho != '0) begin
                                e.bho = e.bho - 16'd1;
                            end
                            e.tho = (e.tho > {4'd0, r_req.elapsed_us})
                                  ? e.tho - {4'd0, r_req.elapsed_us} : '0;
                            case (e.strat)
                                dpb_pkg::STRAT_SWITCH: begin
                                    if (e.bho == '0) begin
                                        high = (e.value >= dpb_pkg::HALF_SCALE);
                                        thr  = high
                                             ? $signed({2'b0, i_cfg.thresh}) - $signed({2'b0, i_cfg.hyst})
                                             : $signed({2'b0, i_cfg.thresh}) + $signed({2'b0, i_cfg.hyst});
                                        want = ($signed({2'b0, r_req.sample_value}) >= thr);
                                        if (want != high) begin
                                            e.value = want ? dpb_pkg::FULL_SCALE : '0;
                                            e.bho   = i_cfg.hold_blk;
                                        end
                                    end
                                end
                                dpb_pkg::STRAT_XFADE: begin
                                    if (r_req.morph_amount >= dpb_pkg::MORPH_LOW &&
                                        r_req.morph_amount < dpb_pkg::MORPH_HIGH) begin
                                        e.value = r_req.sample_value;
                                    end else begin
                                        e.value = (r_req.sample_value >= dpb_pkg::HALF_SCALE)
                                                ? dpb_pkg::FULL_SCALE : '0;
                                    end
                                end
                                dpb_pkg::STRAT_STEP: begin
                                    n_prod  = r_req.sample_value
                                            * dpb_pkg::STEP_W'(e.steps - 9'd1);
                                    n_state = dpb_pkg::S_STEP;
                                end
                                dpb_pkg::STRAT_HOLD: begin
                                    if (r_req.morph_amount >= dpb_pkg::MORPH_HIGH) begin
                                        e.value = r_req.sample_value;
                                    end
                                end
                                dpb_pkg::STRAT_FOLLOW: begin
                                    e.value = r_req.sample_value;
                                end
                                default: begin
                                end
                            endcase
                            n_res = e.value;
                        end
                    end
                endcase
                n_ent = e;
            end
            dpb_pkg::S_STEP: begin
                // divide by 65535: quotient from the high half, one correction
                xq = r_prod + 24'd32767;
                rq = {1'b0, xq[15:0]} + {9'd0, xq[23:16]};
                q  = {1'b0, xq[23:16]} + ((rq >= 17'd65535) ? 9'd1 : 9'd0);
                target = (q > {1'b0, m}) ? m : q[7:0];
                n_res   = r_ent.value;
                n_state = dpb_pkg::S_DONE;
                if (target != r_ent.step && r_ent.tho == '0) begin
                    step_dist = (target > r_ent.step) ? target - r_ent.step
                                                      : r_ent.step - target;
                    if (step_dist == 8'd1) begin
                        n_ent.step = target;
                        n_ent.tho  = {1'b0, i_cfg.hold_time[23:1]};
                    end else begin
                        n_ent.step = (target > r_ent.step) ? r_ent.step + 8'd1
                                                           : r_ent.step - 8'd1;
                        n_ent.tho  = i_cfg.hold_time;
                    end
                    if (m == '0) begin
                        n_ent.value = '0;
                        n_res       = '0;
                    end else begin
                        n_state = dpb_pkg::S_LOAD;
                    end
                end
            end
            dpb_pkg::S_LOAD: begin
                div_start = 1'b1;
                n_state   = dpb_pkg::S_DIV;
            end
            dpb_pkg::S_DIV: begin
                if (div_done) begin
                    n_ent.value = (div_quo > 25'(dpb_pkg::FULL_SCALE))
                                ? dpb_pkg::FULL_SCALE : div_quo[15:0];
                    n_res       = n_ent.value;
                    n_state     = dpb_pkg::S_DONE;
                end
            end
            dpb_pkg::S_DONE: begin
                if (r_req.command != dpb_pkg::CMD_PROCESS) begin
                    we      = 1'b1;
                    n_state = dpb_pkg::S_IDLE;
                end else if (!r_out_valid || o_res.ready) begin
                    we       = 1'b1;
                    out_load = 1'b1;
                    n_state  = dpb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dpb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_ent    <= n_ent;
        r_res    <= n_res;
        r_prod   <= n_prod;
        r_rd_vld <= n_rd_vld;
        if (out_load) begin
            r_out_idx <= r_req.param_index;
            r_out_val <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dpb_pkg::S_IDLE;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (we) begin
                r_vld[r_req.param_index] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end
endmodule

### sv/discrete_param_blend.sv
// Discrete parameter blender. Requests enter through a two-deep queue and are
// executed one at a time against a 256-entry parameter table held in RAM
// (read, update, write back). Write and force requests pass through the calc
// and done states; a process request adds the step state for a stepwise entry,
// and the load and divide states when such an entry of more than one step
// moves, where the step value is formed by a one-bit-per-cycle 25-bit divider. A
// process request gives one result (index and value); write, force and command
// three give none. The table needs no clearing pass: per-entry valid flops make
// unwritten entries read as their reset contents. Results wait in an output
// register, so new requests are taken while a result is pending.
module discrete_param_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dpb_in_if.sink                        i_req,
    dpb_out_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [dpb_pkg::TIME_W-1:0]    i_cfg_data
);
    dpb_pkg::t_cfg   r_cfg;
    dpb_pkg::t_req   q_data;
    logic            q_valid;
    logic            q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thresh    <= dpb_pkg::HALF_SCALE;
            r_cfg.hyst      <= 16'd6554;
            r_cfg.hold_blk  <= 16'd100;
            r_cfg.hold_time <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dpb_pkg::REG_THRESH:    r_cfg.thresh    <= i_cfg_data[15:0];
                dpb_pkg::REG_HYST:      r_cfg.hyst      <= i_cfg_data[15:0];
                dpb_pkg::REG_HOLD_BLK:  r_cfg.hold_blk  <= i_cfg_data[15:0];
                dpb_pkg::REG_HOLD_TIME: r_cfg.hold_time <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dpb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_q_data  (q_data),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop)
    );

    dpb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_data  (q_data),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_cfg_thresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_index == dpb_pkg::REG_THRESH
        |=> r_cfg.thresh == $past(i_cfg_data[15:0]))
        else $error("threshold write lost");
endmodule
